// ===== src/sacr_pkg.sv =====
`timescale 1ns / 1ps
package sacr_pkg;
   localparam int LINES_DEF      = 16;
   localparam int TAG_BITS_DEF   = 32;
   localparam int COUNT_BITS_DEF = 8;
   localparam int ADDR_W         = 32;
   localparam int BSHIFT_W       = 4;
   localparam int SSHIFT_W       = 3;
   localparam int POLICY_W       = 2;
   localparam int IDX_W          = 4;
   localparam int CSR_IDX_W      = 2;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] LFSR_SEED = 16'h0001;

   typedef enum logic [POLICY_W-1:0] {
      POL_RANDOM = 2'd0,
      POL_FIFO   = 2'd1,
      POL_LFU    = 2'd2,
      POL_LRU    = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SHIFT = 2'd0,
      CSR_SET_SHIFT   = 2'd1,
      CSR_POLICY      = 2'd2,
      CSR_NONE        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_WRITE
   } state_type;
endpackage

// ===== src/sacr_if.sv =====
`timescale 1ns / 1ps
interface sacr_req_if;
   import sacr_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacr_rsp_if;
   import sacr_pkg::*;
   logic             valid;
   logic             ready;
   logic             hit;
   logic [IDX_W-1:0] set_index;
   logic [IDX_W-1:0] way_index;
   modport source (output valid, output hit, output set_index, output way_index, input ready);
   modport sink   (input valid, input hit, input set_index, input way_index, output ready);
endinterface

interface sacr_csr_if;
   import sacr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [3:0]           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sacr_ram.sv =====
`timescale 1ns / 1ps
module sacr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/set_assoc_cache_replacement.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req     | in  | valid/ready | address[31:0]
// rsp     | out | valid/ready | hit, set_index[3:0], way_index[3:0]
// csr     | in  | valid/ready | index[1:0], data[3:0]
// one transaction is a sweep over the ways of the set, each way a read of the tag memory and
// of the counter flip-flops, then one update pass of the set's counters and, on a miss, its tag.
// the sweep length is set by the single read port of the tag memory.
// reset is synchronous; valid bits live in flip-flops and clear at once.
// the result waits in an output register; req stalls until it is taken.
module set_assoc_cache_replacement
   import sacr_pkg::*;
#(
   parameter int LINES      = LINES_DEF,
   parameter int TAG_BITS   = TAG_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input logic clock,
   input logic reset,
   sacr_req_if.sink   req,
   sacr_rsp_if.source rsp,
   sacr_csr_if.sink   csr
);
   localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int WW = LW + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam int SMAX = (LW < 4) ? $clog2(LINES) : 4;

   logic [BSHIFT_W-1:0] bshift_ff;
   logic [SSHIFT_W-1:0] sshift_ff;
   policy_type          policy_ff;
   state_type           state_ff, state_in;
   logic [LINES-1:0]    valid_ff;
   logic [15:0]         lfsr_ff;
   logic [7:0]          aclock_ff;

   logic [TAG_BITS-1:0] tag_ff;
   logic [LW-1:0]       base_ff;
   logic [IDX_W-1:0]    set_ff;
   logic [WW-1:0]       ways_ff, rd_way_ff, cnt_way_ff;
   logic                found_ff, empty_ff;
   logic [WW-1:0]       hway_ff, eway_ff, vway_ff;
   logic [COUNT_BITS-1:0] vcnt_ff, hcnt_ff;
   logic [COUNT_BITS-1:0] cnt_mem [LINES];
   logic                rsp_valid_ff, rsp_hit_ff;
   logic [IDX_W-1:0]    rsp_way_ff;

   logic [TAG_BITS-1:0] tag_rd;
   logic                tag_we;
   logic [LW-1:0]       tag_ra, line;

   // counters are stored in a flip-flop array read by line index; tags in sacr_ram
   sacr_ram #(.WIDTH(TAG_BITS), .DEPTH(LINES)) u_tag (
      .clock(clock), .wr_en(tag_we), .wr_addr(line), .wr_data(tag_ff),
      .rd_addr(tag_ra), .rd_data(tag_rd)
   );

   logic [SSHIFT_W-1:0] s_eff;
   always_comb begin
      s_eff = (sshift_ff > SSHIFT_W'(SMAX)) ? SSHIFT_W'(SMAX) : sshift_ff;
   end

   logic [ADDR_W-1:0] blk;
   assign blk = req.address >> bshift_ff;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.hit = rsp_hit_ff;
   assign rsp.set_index = set_ff;
   assign rsp.way_index = rsp_way_ff;

   logic [LW-1:0] rd_line;
   assign rd_line = base_ff + LW'(rd_way_ff);
   assign tag_ra = rd_line;

   logic [WW-1:0] sel_way;
   logic          hit_w;
   logic [WW-1:0] rnd_way;
   logic [15:0]   lfsr_nx;
   assign lfsr_nx = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign rnd_way = WW'(lfsr_nx & 16'(ways_ff - 1'b1));
   always_comb begin
      hit_w = found_ff;
      priority if (found_ff) sel_way = hway_ff;
      else if (empty_ff) sel_way = eway_ff;
      else if (policy_ff == POL_RANDOM) sel_way = rnd_way;
      else sel_way = vway_ff;
   end
   assign line = base_ff + LW'(hit_w ? hway_ff : sel_way);
   assign tag_we = (state_ff == ST_WRITE) && !hit_w;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req.valid && req.ready) state_in = ST_READ;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  if (cnt_way_ff == ways_ff) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // one way per cycle: tag read issued in READ/EVAL, compared in the cycle after
   logic [LW-1:0] cmp_line;
   assign cmp_line = base_ff + LW'(cnt_way_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bshift_ff <= '0;
         sshift_ff <= '0;
         policy_ff <= POL_LRU;
         valid_ff <= '0;
         lfsr_ff <= LFSR_SEED;
         aclock_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LINES; i++) cnt_mem[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            unique case (csr_index_type'(csr.index))
               CSR_BLOCK_SHIFT: bshift_ff <= csr.data;
               CSR_SET_SHIFT:   sshift_ff <= csr.data[SSHIFT_W-1:0];
               CSR_POLICY:      policy_ff <= policy_type'(csr.data[POLICY_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req.valid && req.ready) begin
               tag_ff <= TAG_BITS'(blk >> s_eff);
               set_ff <= IDX_W'(blk & ((ADDR_W'(1) << s_eff) - 1));
               base_ff <= LW'((blk & ((ADDR_W'(1) << s_eff) - 1)) * (LINES >> s_eff));
               ways_ff <= WW'(LINES >> s_eff);
               rd_way_ff <= '0;
               cnt_way_ff <= '0;
               found_ff <= 1'b0;
               empty_ff <= 1'b0;
               vway_ff <= '0;
            end
            ST_READ: rd_way_ff <= rd_way_ff + 1'b1;
            ST_EVAL: if (cnt_way_ff != ways_ff) begin
               rd_way_ff <= rd_way_ff + 1'b1;
               cnt_way_ff <= cnt_way_ff + 1'b1;
               if (!found_ff && valid_ff[cmp_line] && tag_rd == tag_ff) begin
                  found_ff <= 1'b1;
                  hway_ff <= cnt_way_ff;
                  hcnt_ff <= cnt_mem[cmp_line];
               end
               if (!empty_ff && !valid_ff[cmp_line]) begin
                  empty_ff <= 1'b1;
                  eway_ff <= cnt_way_ff;
               end
               if (cnt_way_ff == '0) begin
                  vcnt_ff <= cnt_mem[cmp_line];
               end else if ((policy_ff == POL_LFU) ? (cnt_mem[cmp_line] < vcnt_ff)
                                                   : (cnt_mem[cmp_line] > vcnt_ff)) begin
                  vcnt_ff <= cnt_mem[cmp_line];
                  vway_ff <= cnt_way_ff;
               end
            end
            ST_WRITE: begin
               aclock_ff <= aclock_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               rsp_hit_ff <= hit_w;
               rsp_way_ff <= IDX_W'(sel_way);
               if (!hit_w) valid_ff[line] <= 1'b1;
               if (!hit_w && !empty_ff && policy_ff == POL_RANDOM) lfsr_ff <= lfsr_nx;
               for (int w = 0; w < LINES; w++) begin
                  if (WW'(w) < ways_ff) begin
                     if (LW'(w) + base_ff == line) begin
                        if (policy_ff == POL_LFU)
                           cnt_mem[line] <= hit_w ? ((hcnt_ff == CMAX) ? CMAX : hcnt_ff + 1'b1)
                                                  : COUNT_BITS'(1);
                        else if (policy_ff != POL_RANDOM && (hit_w ? policy_ff == POL_LRU : 1'b1))
                           cnt_mem[line] <= '0;
                     end else if (valid_ff[LW'(w) + base_ff] && policy_ff != POL_RANDOM
                                  && policy_ff != POL_LFU
                                  && (!hit_w || (policy_ff == POL_LRU
                                      && cnt_mem[LW'(w) + base_ff] < hcnt_ff))) begin
                        if (cnt_mem[LW'(w) + base_ff] != CMAX)
                           cnt_mem[LW'(w) + base_ff] <= cnt_mem[LW'(w) + base_ff] + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== tb/set_assoc_cache_replacement_tb.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_replacement_tb;
   import sacr_pkg::*;

   localparam int NUM_LINES = 16;
   localparam int CNT_MAX   = 255;
   localparam int DRAIN_CYC = 40;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] set_index;
      logic [IDX_W-1:0] way_index;
   } lookup_t;

   typedef struct {
      logic [31:0] addr;
      bit          typed;
      lookup_t     res;
   } dir_row_t;

   logic clock;
   logic reset;

   sacr_req_if req_ch ();
   sacr_rsp_if rsp_ch ();
   sacr_csr_if csr_ch ();

   set_assoc_cache_replacement i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source),
      .csr  (csr_ch.sink)
   );

   // shadow copy of the directory
   logic [31:0]         tag_mem   [NUM_LINES];
   bit                  line_vld  [NUM_LINES];
   int                  age_cnt   [NUM_LINES];
   logic [15:0]         lfsr_q;
   logic [BSHIFT_W-1:0] blk_shift_q;
   logic [SSHIFT_W-1:0] set_shift_q;
   policy_type          policy_q;

   lookup_t  lookup_q[$];
   dir_row_t dir_rows[$];
   int       err_cnt;
   int       n_sent;
   int       n_hits;
   int       n_miss;
   int       hold_cnt;
   bit       long_hold_req;
   bit       rsp_quiet;
   bit       req_quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int sat_inc(int v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1;
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic lookup_t lookup_predict(logic [31:0] addr);
      int          s, ways, base, way, r;
      logic [31:0] blk, set, tag;
      bit          hit, found;
      lookup_t     res;
      s = (set_shift_q > 4) ? 4 : set_shift_q;
      ways = NUM_LINES >> s;
      blk = addr >> blk_shift_q;
      set = blk & ((32'd1 << s) - 1);
      tag = blk >> s;
      base = set * ways;
      hit = 0;
      found = 0;
      way = 0;
      for (int w = 0; w < ways; w++) begin
         if (!hit && line_vld[base+w] && tag_mem[base+w] == tag) begin
            hit = 1;
            way = w;
         end
      end
      if (hit) begin
         if (policy_q == POL_LFU) begin
            age_cnt[base+way] = sat_inc(age_cnt[base+way]);
         end else if (policy_q == POL_LRU) begin
            r = age_cnt[base+way];
            for (int w = 0; w < ways; w++)
               if (w != way && line_vld[base+w] && age_cnt[base+w] < r)
                  age_cnt[base+w] = sat_inc(age_cnt[base+w]);
            age_cnt[base+way] = 0;
         end
      end else begin
         for (int w = 0; w < ways; w++) begin
            if (!found && !line_vld[base+w]) begin
               found = 1;
               way = w;
            end
         end
         if (!found) begin
            if (policy_q == POL_RANDOM) begin
               lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
               way = lfsr_q % ways;
            end else if (policy_q == POL_LFU) begin
               way = 0;
               for (int w = 1; w < ways; w++)
                  if (age_cnt[base+w] < age_cnt[base+way]) way = w;
            end else begin
               way = 0;
               for (int w = 1; w < ways; w++)
                  if (age_cnt[base+w] > age_cnt[base+way]) way = w;
            end
         end
         tag_mem[base+way] = tag;
         line_vld[base+way] = 1;
         if (policy_q == POL_FIFO || policy_q == POL_LRU) begin
            for (int w = 0; w < ways; w++)
               if (w != way && line_vld[base+w])
                  age_cnt[base+w] = sat_inc(age_cnt[base+w]);
            age_cnt[base+way] = 0;
         end else if (policy_q == POL_LFU) begin
            age_cnt[base+way] = 1;
         end
      end
      res.hit = hit;
      res.set_index = set[IDX_W-1:0];
      res.way_index = way[IDX_W-1:0];
      return res;
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_lookup(logic [31:0] addr, bit typed, lookup_t typed_res);
      lookup_t pred;
      int      g;
      req_ch.valid <= 1'b1;
      req_ch.address <= addr;
      do @(posedge clock); while (!req_ch.ready);
      pred = lookup_predict(addr);
      lookup_q.push_back(typed ? typed_res : pred);
      n_sent++;
      if (pred.hit) n_hits++;
      else n_miss++;
      @(negedge clock);
      g = req_quiet ? 0 : rand_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      while (lookup_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [3:0] data);
      req_ch.valid <= 1'b0;
      wait_drain();
      repeat (DRAIN_CYC) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_BLOCK_SHIFT: blk_shift_q = data;
         CSR_SET_SHIFT:   set_shift_q = data[SSHIFT_W-1:0];
         CSR_POLICY:      policy_q = policy_type'(data[POLICY_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_geometry(logic [3:0] bs, logic [3:0] ss, logic [3:0] pol);
      csr_write(CSR_BLOCK_SHIFT, bs);
      csr_write(CSR_SET_SHIFT, ss);
      csr_write(CSR_POLICY, pol);
   endtask

   function automatic lookup_t mk_res(bit h, int s, int w);
      lookup_t r;
      r.hit = h;
      r.set_index = s[IDX_W-1:0];
      r.way_index = w[IDX_W-1:0];
      return r;
   endfunction

   // receiver with random back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      hold_cnt = 0;
      forever begin
         int g;
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt--;
         end else if (long_hold_req) begin
            rsp_ch.ready <= 1'b0;
            long_hold_req = 0;
            hold_cnt = 150;
         end else if (rsp_quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            g = rand_gap();
            if (g == 0) rsp_ch.ready <= 1'b1;
            else begin
               rsp_ch.ready <= 1'b0;
               hold_cnt = g - 1;
            end
         end
      end
   end

   // result checker
   initial begin
      forever begin
         lookup_t want;
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (lookup_q.size() == 0) begin
               $error("unexpected response transaction");
               err_cnt++;
            end else begin
               want = lookup_q.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
                  err_cnt++;
               end
               if (rsp_ch.set_index !== want.set_index) begin
                  $error("set_index: expected %0d, got %0d", want.set_index,
                         rsp_ch.set_index);
                  err_cnt++;
               end
               if (rsp_ch.way_index !== want.way_index) begin
                  $error("way_index: expected %0d, got %0d", want.way_index,
                         rsp_ch.way_index);
                  err_cnt++;
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] pool[$];
      logic [31:0] a;
      logic [3:0]  bs, ss, pol;
      int          n_pool, n_items;
      err_cnt = 0;
      n_sent = 0;
      n_hits = 0;
      n_miss = 0;
      long_hold_req = 0;
      rsp_quiet = 0;
      req_quiet = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.address = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_BLOCK_SHIFT;
      csr_ch.data = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         tag_mem[i] = '0;
         line_vld[i] = 0;
         age_cnt[i] = 0;
      end
      lfsr_q = LFSR_SEED;
      blk_shift_q = '0;
      set_shift_q = '0;
      policy_q = POL_LRU;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYC) @(negedge clock);

      // reset geometry: one set of sixteen ways, lru
      dir_rows.push_back('{32'h0000_0000, 1, mk_res(0, 0, 0)});
      dir_rows.push_back('{32'h0000_0000, 1, mk_res(1, 0, 0)});
      dir_rows.push_back('{32'hFFFF_FFFF, 1, mk_res(0, 0, 1)});
      dir_rows.push_back('{32'hFFFF_FFFF, 1, mk_res(1, 0, 1)});
      for (int k = 0; k < 14; k++)
         dir_rows.push_back('{32'd1 << k, (k == 0), mk_res(0, 0, 2)});
      // set full: least recent line is way 0
      dir_rows.push_back('{32'h5555_5555, 1, mk_res(0, 0, 0)});
      dir_rows.push_back('{32'hAAAA_AAAA, 0, mk_res(0, 0, 0)});
      foreach (dir_rows[i]) send_lookup(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);

      // oversized set shift clamps to sixteen sets; top block shift
      set_geometry(4'd15, 4'd7, POL_FIFO);
      send_lookup(32'hFFFF_FFFF, 0, '0);
      send_lookup(32'h0000_0000, 0, '0);
      send_lookup(32'h0007_FFFF, 0, '0);
      csr_write(CSR_NONE, 4'hF);
      send_lookup(32'h0008_0000, 0, '0);

      for (int ph = 0; ph < 11; ph++) begin
         case (ph % 4)
            0: bs = 4'd0;
            1: bs = 4'd15;
            default: bs = $urandom_range(0, 8);
         endcase
         case (ph % 3)
            0: ss = 4'd4;
            1: ss = $urandom_range(5, 7);
            default: ss = $urandom_range(0, 3);
         endcase
         pol = (ph < 8) ? ph % 4 : $urandom_range(0, 3);
         if (ph == 6) ss = 4'd0;
         set_geometry(bs, ss, pol);
         rsp_quiet = (ph == 2);
         req_quiet = (ph == 2 || ph == 5);
         pool.delete();
         n_pool = $urandom_range(4, 28);
         for (int i = 0; i < n_pool; i++) pool.push_back($urandom());
         // lfu phase sends most lookups to one hot line, raising its count
         n_items = (ph == 6) ? 300 : 80;
         for (int i = 0; i < n_items; i++) begin
            if (ph == 3 && i == 10) long_hold_req = 1;
            if (ph == 6 && $urandom_range(0, 9) < 8) a = pool[0];
            else if ($urandom_range(0, 3) != 0)
               a = pool[$urandom_range(0, n_pool - 1)] ^
                   ($urandom() & ((32'd1 << bs) - 1));
            else a = $urandom();
            send_lookup(a, 0, '0);
            if (ph == 4 && i == 40) begin
               // sender pauses until every result is back
               req_ch.valid <= 1'b0;
               wait_drain();
               @(negedge clock);
            end
         end
      end

      req_ch.valid <= 1'b0;
      rsp_quiet = 1;
      wait_drain();
      repeat (DRAIN_CYC) @(posedge clock);
      $display("lookups: %0d (%0d hits, %0d misses) over all four policies,",
               n_sent, n_hits, n_miss);
      $display("set shifts 0..7, block shifts 0..15, with back-pressure on both sides");
      if (err_cnt == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sacr_pkg.sv
src/sacr_if.sv
src/sacr_ram.sv
src/set_assoc_cache_replacement.sv
tb/set_assoc_cache_replacement_tb.sv
